@@ design/lwc_pkg.sv @@
// Shared types and codes for the LRU write-back cache.
package lwc_pkg;

    typedef enum logic [1:0] {
        K_GET   = 2'd0,
        K_SET   = 2'd1,
        K_FILL  = 2'd2,
        K_FLUSH = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RK_READ      = 3'd0,
        RK_NOTFOUND  = 3'd1,
        RK_FETCH     = 3'd2,
        RK_WRITEBACK = 3'd3,
        RK_SETDONE   = 3'd4,
        RK_FLUSHDONE = 3'd5
    } t_rkind;

    localparam int unsigned CAP_BITS  = 5;
    localparam int unsigned CAP_RESET = 16;
    localparam int unsigned KIND_BITS = 2;
    localparam int unsigned RK_BITS   = 3;
    localparam int unsigned OKEY_BITS = 32;
    localparam int unsigned OVAL_BITS = 64;

endpackage

@@ design/lwc_front.sv @@
// Front end: accept items and queue them in order for the back end.
module lwc_front #(
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned QDEPTH     = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_kind,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [VALUE_BITS-1:0]   i_value,
    input  logic                    i_found,
    input  logic                    i_qpop,
    output logic                    o_qvalid,
    output logic [1:0]              o_qkind,
    output logic [KEY_BITS-1:0]     o_qkey,
    output logic [VALUE_BITS-1:0]   o_qvalue,
    output logic                    o_qfound
);
    import lwc_pkg::*;

    localparam int unsigned PW = $clog2(QDEPTH);

    logic [1:0]            r_kind  [QDEPTH];
    logic [KEY_BITS-1:0]   r_key   [QDEPTH];
    logic [VALUE_BITS-1:0] r_value [QDEPTH];
    logic                  r_found [QDEPTH];
    logic [PW-1:0]         r_wp, r_rp;
    logic [PW:0]           r_cnt;
    logic                  push;

    assign o_stall  = (r_cnt == (PW+1)'(QDEPTH));
    assign push     = i_valid && !o_stall;
    assign o_qvalid = (r_cnt != '0);
    assign o_qkind  = r_kind[r_rp];
    assign o_qkey   = r_key[r_rp];
    assign o_qvalue = r_value[r_rp];
    assign o_qfound = r_found[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[r_wp]  <= i_kind;
            r_key[r_wp]   <= i_key;
            r_value[r_wp] <= i_value;
            r_found[r_wp] <= i_found;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_qpop) r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_qpop);
        end
    end
endmodule

@@ design/lwc_back.sv @@
// Back end: sequencer that scans entries, updates recency and emits results.
module lwc_back #(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lwc_pkg::CAP_BITS-1:0]  i_capacity,
    input  logic                          i_qvalid,
    output logic                          o_qpop,
    input  logic [1:0]                    i_qkind,
    input  logic [KEY_BITS-1:0]           i_qkey,
    input  logic [VALUE_BITS-1:0]         i_qvalue,
    input  logic                          i_qfound,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lwc_pkg::RK_BITS-1:0]   o_rkind,
    output logic [lwc_pkg::OKEY_BITS-1:0] o_rkey,
    output logic [lwc_pkg::OVAL_BITS-1:0] o_rvalue,
    output logic                          o_last
);
    import lwc_pkg::*;

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned RW = IW;
    localparam int unsigned OW = $clog2(ENTRIES + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_FIND  = 8'b00000010,
        S_HIT   = 8'b00000100,
        S_MISS  = 8'b00001000,
        S_EVICT = 8'b00010000,
        S_WB    = 8'b00100000,
        S_INS   = 8'b01000000,
        S_FLUSH = 8'b10000000
    } t_state;

    t_state                r_state;
    logic [1:0]            r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_found;
    logic [IW:0]           r_idx;
    logic [RW:0]           r_rank;
    logic                  r_hit;
    logic [IW-1:0]         r_slot;
    logic                  r_vsel;
    logic [RW-1:0]         r_best;
    logic [IW-1:0]         r_vic;
    logic                  r_wbv;

    logic [KEY_BITS-1:0]   r_keys   [ENTRIES];
    logic [VALUE_BITS-1:0] r_vals   [ENTRIES];
    logic [ENTRIES-1:0]    r_valid, r_dirty;
    logic [RW-1:0]         r_rk     [ENTRIES];
    logic [OW-1:0]         r_occ;
    logic                  r_await;
    logic [KEY_BITS-1:0]   r_pend;

    logic                  r_ov;
    logic [RK_BITS-1:0]    r_ok;
    logic [OKEY_BITS-1:0]  r_okey;
    logic [OVAL_BITS-1:0]  r_oval;
    logic                  r_olast;

    logic                  out_free;
    logic                  load_out;
    logic [IW-1:0]         idx;
    logic [OW-1:0]         effcap;
    logic                  free_found;
    logic [IW-1:0]         free_slot;

    assign out_free = !r_ov || !i_stall;
    assign idx      = r_idx[IW-1:0];
    assign o_valid  = r_ov;
    assign o_rkind  = r_ok;
    assign o_rkey   = r_okey;
    assign o_rvalue = r_oval;
    assign o_last   = r_olast;
    assign o_qpop   = (r_state == S_IDLE) && i_qvalid;

    always_comb begin
        if (i_capacity == '0) effcap = OW'(1);
        else if (32'(i_capacity) > ENTRIES) effcap = OW'(ENTRIES);
        else effcap = OW'(i_capacity);
    end

    // the current state wants to load the output register
    always_comb begin
        case (r_state)
            S_HIT:   load_out = 1'b1;
            S_MISS:  load_out = (t_kind'(r_kind) == K_GET)
                                || (t_kind'(r_kind) == K_FILL && !r_found);
            S_WB:    load_out = r_vsel && r_dirty[r_vic] && !r_wbv;
            S_INS:   load_out = 1'b1;
            S_FLUSH: load_out = (r_rank == (RW+1)'(ENTRIES))
                                || (r_valid[idx] && r_dirty[idx]
                                    && r_rk[idx] == r_rank[RW-1:0]);
            default: load_out = 1'b0;
        endcase
    end

    // lowest free slot, found by a priority pick
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_slot  = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_dirty <= '0;
            r_occ   <= '0;
            r_await <= 1'b0;
            r_pend  <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) r_rk[i] <= '0;
        end else begin
            if (r_ov && !i_stall && !load_out) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_qvalid) begin
                        r_kind  <= i_qkind;
                        r_key   <= (t_kind'(i_qkind) == K_FILL) ? r_pend : i_qkey;
                        r_val   <= i_qvalue;
                        r_found <= i_qfound;
                        r_idx   <= '0;
                        r_rank  <= '0;
                        r_hit   <= 1'b0;
                        if (t_kind'(i_qkind) == K_FLUSH) begin
                            r_state <= S_FLUSH;
                        end else if (t_kind'(i_qkind) == K_FILL) begin
                            if (r_await) begin
                                r_await <= 1'b0;
                                r_state <= S_FIND;
                            end
                        end else begin
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    // one entry per cycle
                    if (r_valid[idx] && r_keys[idx] == r_key && !r_hit) begin
                        r_hit  <= 1'b1;
                        r_slot <= idx;
                    end
                    if (r_idx == (IW+1)'(ENTRIES - 1)) begin
                        if (r_hit || (r_valid[idx] && r_keys[idx] == r_key))
                            r_state <= S_HIT;
                        else
                            r_state <= S_MISS;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_HIT: begin
                    if (out_free) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (r_valid[i] && IW'(i) != r_slot && r_rk[i] < r_rk[r_slot])
                                r_rk[i] <= r_rk[i] + 1'b1;
                        r_rk[r_slot] <= '0;
                        r_ov    <= 1'b1;
                        r_okey  <= '0;
                        r_olast <= 1'b1;
                        if (t_kind'(r_kind) == K_SET) begin
                            r_vals[r_slot]  <= r_val;
                            r_dirty[r_slot] <= 1'b1;
                            r_ok   <= RK_SETDONE;
                            r_oval <= '0;
                        end else begin
                            r_ok   <= RK_READ;
                            r_oval <= OVAL_BITS'(r_vals[r_slot]);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_MISS: begin
                    if (t_kind'(r_kind) == K_GET) begin
                        if (out_free) begin
                            r_await <= 1'b1;
                            r_pend  <= r_key;
                            r_ov    <= 1'b1;
                            r_ok    <= RK_FETCH;
                            r_okey  <= OKEY_BITS'(r_key);
                            r_oval  <= '0;
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else if (t_kind'(r_kind) == K_FILL && !r_found) begin
                        if (out_free) begin
                            r_ov    <= 1'b1;
                            r_ok    <= RK_NOTFOUND;
                            r_okey  <= '0;
                            r_oval  <= '0;
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx  <= '0;
                        r_vsel <= 1'b0;
                        r_best <= '0;
                        r_wbv  <= 1'b0;
                        if (r_occ >= effcap) r_state <= S_EVICT;
                        else if (free_found) begin
                            r_slot  <= free_slot;
                            r_occ   <= r_occ + 1'b1;
                            r_state <= S_INS;
                        end else r_state <= S_INS;
                    end
                end
                S_EVICT: begin
                    // LRU search, last of equal ranks wins
                    if (r_valid[idx] && (!r_vsel || r_rk[idx] >= r_best)) begin
                        r_vsel <= 1'b1;
                        r_best <= r_rk[idx];
                        r_vic  <= idx;
                    end
                    if (r_idx == (IW+1)'(ENTRIES - 1)) r_state <= S_WB;
                    r_idx <= r_idx + 1'b1;
                end
                S_WB: begin
                    if (!r_vsel) begin
                        r_hit   <= 1'b1;
                        r_state <= S_INS;
                    end else if (r_dirty[r_vic] && !r_wbv) begin
                        if (out_free) begin
                            r_ov    <= 1'b1;
                            r_ok    <= RK_WRITEBACK;
                            r_okey  <= OKEY_BITS'(r_keys[r_vic]);
                            r_oval  <= OVAL_BITS'(r_vals[r_vic]);
                            r_olast <= 1'b0;
                            r_wbv   <= 1'b1;
                        end
                    end else begin
                        r_valid[r_vic] <= 1'b0;
                        r_slot  <= r_vic;
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    // r_hit set here means no slot could be found: skip the insert
                    if (out_free) begin
                        if (!r_hit && (r_vsel || free_found || r_occ != '0)) begin
                            for (int i = 0; i < ENTRIES; i++)
                                if (r_valid[i]) r_rk[i] <= r_rk[i] + 1'b1;
                            r_keys[r_slot]  <= r_key;
                            r_vals[r_slot]  <= r_val;
                            r_valid[r_slot] <= 1'b1;
                            r_dirty[r_slot] <= (t_kind'(r_kind) == K_SET);
                            r_rk[r_slot]    <= '0;
                        end
                        r_ov    <= 1'b1;
                        r_okey  <= '0;
                        r_olast <= 1'b1;
                        if (t_kind'(r_kind) == K_SET) begin
                            r_ok   <= RK_SETDONE;
                            r_oval <= '0;
                        end else begin
                            r_ok   <= RK_READ;
                            r_oval <= OVAL_BITS'(r_val);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    // walk ranks outer, slots inner
                    if (r_rank == (RW+1)'(ENTRIES)) begin
                        if (out_free) begin
                            r_ov    <= 1'b1;
                            r_ok    <= RK_FLUSHDONE;
                            r_okey  <= '0;
                            r_oval  <= '0;
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else if (r_valid[idx] && r_dirty[idx]
                                 && r_rk[idx] == r_rank[RW-1:0]) begin
                        if (out_free) begin
                            r_ov    <= 1'b1;
                            r_ok    <= RK_WRITEBACK;
                            r_okey  <= OKEY_BITS'(r_keys[idx]);
                            r_oval  <= OVAL_BITS'(r_vals[idx]);
                            r_olast <= 1'b0;
                            r_dirty[idx] <= 1'b0;
                        end
                    end else begin
                        if (r_idx == (IW+1)'(ENTRIES - 1)) begin
                            r_idx  <= '0;
                            r_rank <= r_rank + 1'b1;
                        end else r_idx <= r_idx + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/lru_writeback_cache_top.sv @@
// Top level of the LRU write-back cache: front queue, back sequencer, capacity register.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+-----------------------------------------------
//  in      | i_valid  | o_stall  | i_kind i_lookup_key i_write_value i_fill_found
//  out     | o_valid  | i_stall  | o_result_kind o_result_key o_result_value o_last
//  cfg     | i_cfg_we | -        | i_cfg_data (capacity)
//
// A two-entry queue lets the front take items while the back works.
// The back walks entries one per cycle: a get or set scans them once, an insert
// with eviction scans them again for the victim, and a flush walks every slot for
// each rank and adds a write-back where one is due; the scan sets the rate.
// Reset (synchronous, active low) clears valid, dirty, ranks and queue.
// Output stalls hold result-emitting states; input stalls come from the full queue.
module lru_writeback_cache_top #(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lwc_pkg::CAP_BITS-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_kind,
    input  logic [31:0]                   i_lookup_key,
    input  logic [63:0]                   i_write_value,
    input  logic                          i_fill_found,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_result_kind,
    output logic [31:0]                   o_result_key,
    output logic [63:0]                   o_result_value,
    output logic                          o_last
);
    import lwc_pkg::*;

    logic [CAP_BITS-1:0]   r_capacity;
    logic                  qpop, qvalid, qfound;
    logic [1:0]            qkind;
    logic [KEY_BITS-1:0]   qkey;
    logic [VALUE_BITS-1:0] qvalue;

    // capacity register; out-of-range values are clamped in the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_capacity <= CAP_BITS'(CAP_RESET);
        else if (i_cfg_we) r_capacity <= i_cfg_data;
    end

    lwc_front #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .QDEPTH     (2)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_key    (KEY_BITS'(i_lookup_key)),
        .i_value  (VALUE_BITS'(i_write_value)),
        .i_found  (i_fill_found),
        .i_qpop   (qpop),
        .o_qvalid (qvalid),
        .o_qkind  (qkind),
        .o_qkey   (qkey),
        .o_qvalue (qvalue),
        .o_qfound (qfound)
    );

    lwc_back #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_qvalid   (qvalid),
        .o_qpop     (qpop),
        .i_qkind    (qkind),
        .i_qkey     (qkey),
        .i_qvalue   (qvalue),
        .i_qfound   (qfound),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rkind    (o_result_kind),
        .o_rkey     (o_result_key),
        .o_rvalue   (o_result_value),
        .o_last     (o_last)
    );
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the LRU write-back cache top level.
`timescale 1ns / 1ps

module tb;
    import lwc_pkg::*;

    localparam int unsigned NWAYS     = 16;
    localparam int unsigned DRAIN_CYC = 400;     // a full flush walk plus margin
    localparam int unsigned CYC_LIMIT = 2000000;

    typedef struct {
        t_rkind      kind;
        logic [31:0] key;
        logic [63:0] value;
        logic        last;
    } result_t;

    // One stimulus row: a capacity write beforehand (when cap_we is set), then one
    // transfer. n_typed >= 0 means the expected results are typed in the row.
    typedef struct {
        logic        cap_we;
        logic [4:0]  cap;
        t_kind       kind;
        logic [31:0] key;
        logic [63:0] value;
        logic        found;
        int          n_typed;
        result_t     typed;
    } row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [31:0] i_lookup_key;
    logic [63:0] i_write_value;
    logic        i_fill_found;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_result_kind;
    logic [31:0] o_result_key;
    logic [63:0] o_result_value;
    logic        o_last;

    lru_writeback_cache_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_lookup_key   (i_lookup_key),
        .i_write_value  (i_write_value),
        .i_fill_found   (i_fill_found),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_result_key   (o_result_key),
        .o_result_value (o_result_value),
        .o_last         (o_last)
    );

    // Cache mirror: contents, recency and the outstanding miss.
    logic [31:0] way_key   [NWAYS];
    logic [63:0] way_value [NWAYS];
    logic        way_valid [NWAYS];
    logic        way_dirty [NWAYS];
    int unsigned way_age   [NWAYS];
    int unsigned fill_count;
    logic        miss_open;
    logic [31:0] miss_key;
    logic [4:0]  cap_reg;

    result_t     pending_results[$];
    result_t     new_results[$];
    row_t        rows[$];
    logic [31:0] key_pool[$];
    int unsigned fail_count;
    int unsigned cycle_count;
    logic        quiet;              // no idling on either side

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int find_way(logic [31:0] k);
        for (int i = 0; i < NWAYS; i++)
            if (way_valid[i] && way_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void make_newest(int w);
        for (int i = 0; i < NWAYS; i++)
            if (way_valid[i] && i != w && way_age[i] < way_age[w])
                way_age[i]++;
        way_age[w] = 0;
    endfunction

    function automatic void add_result(t_rkind k, logic [31:0] key, logic [63:0] v, logic l);
        result_t r;
        r.kind = k; r.key = key; r.value = v; r.last = l;
        new_results.push_back(r);
    endfunction

    function automatic int unsigned live_cap();
        if (cap_reg == 0) return 1;
        if (cap_reg > NWAYS) return NWAYS;
        return 32'(cap_reg);
    endfunction

    // Place a new newest entry; evict the oldest (last of equal age) when full.
    function automatic void place_entry(logic [31:0] k, logic [63:0] v, logic d);
        int w;
        int unsigned oldest;
        w = -1;
        oldest = 0;
        if (fill_count >= live_cap()) begin
            for (int i = 0; i < NWAYS; i++)
                if (way_valid[i] && (w < 0 || way_age[i] >= oldest)) begin
                    w = i;
                    oldest = way_age[i];
                end
            if (w < 0) return;
            if (way_dirty[w])
                add_result(RK_WRITEBACK, way_key[w], way_value[w], 1'b0);
            way_valid[w] = 1'b0;
        end else begin
            for (int i = 0; i < NWAYS && w < 0; i++)
                if (!way_valid[i]) w = i;
            if (w < 0) return;
            fill_count++;
        end
        for (int i = 0; i < NWAYS; i++)
            if (way_valid[i]) way_age[i]++;
        way_key[w] = k; way_value[w] = v; way_valid[w] = 1'b1;
        way_dirty[w] = d; way_age[w] = 0;
    endfunction

    // Advance the mirror by one accepted transfer; results go to new_results.
    function automatic void cache_step(t_kind k, logic [31:0] key, logic [63:0] v, logic found);
        int w;
        new_results.delete();
        case (k)
            K_GET: begin
                w = find_way(key);
                if (w >= 0) begin
                    make_newest(w);
                    add_result(RK_READ, '0, way_value[w], 1'b1);
                end else begin
                    miss_open = 1'b1;
                    miss_key = key;
                    add_result(RK_FETCH, key, '0, 1'b1);
                end
            end
            K_SET: begin
                w = find_way(key);
                if (w >= 0) begin
                    way_value[w] = v;
                    way_dirty[w] = 1'b1;
                    make_newest(w);
                end else begin
                    place_entry(key, v, 1'b1);
                end
                add_result(RK_SETDONE, '0, '0, 1'b1);
            end
            K_FILL: begin
                if (miss_open) begin
                    miss_open = 1'b0;
                    w = find_way(miss_key);
                    if (w >= 0) begin
                        make_newest(w);
                        add_result(RK_READ, '0, way_value[w], 1'b1);
                    end else if (!found) begin
                        add_result(RK_NOTFOUND, '0, '0, 1'b1);
                    end else begin
                        place_entry(miss_key, v, 1'b0);
                        add_result(RK_READ, '0, v, 1'b1);
                    end
                end
            end
            default: begin
                for (int r = 0; r < NWAYS; r++)
                    for (int i = 0; i < NWAYS; i++)
                        if (way_valid[i] && way_age[i] == r && way_dirty[i]) begin
                            add_result(RK_WRITEBACK, way_key[i], way_value[i], 1'b0);
                            way_dirty[i] = 1'b0;
                        end
                add_result(RK_FLUSHDONE, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // Drive one transfer, starting at a falling edge; return at the falling edge after it.
    task automatic send_item(t_kind k, logic [31:0] key, logic [63:0] v, logic found,
                             int n_typed, result_t typed);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= k;
        i_lookup_key  <= key;
        i_write_value <= v;
        i_fill_found  <= found;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        cache_step(k, key, v, found);
        if (n_typed < 0) begin
            foreach (new_results[i]) pending_results.push_back(new_results[i]);
        end else if (n_typed > 0) begin
            pending_results.push_back(typed);
        end
        @(negedge i_clk);
    endtask

    // Drop valid, let the block drain, then hold for a possible silent fill.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_cap(logic [4:0] c);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_reg = c;
        @(negedge i_clk);
    endtask

    function automatic void add_row(logic cw, logic [4:0] c, t_kind k, logic [31:0] key,
                                    logic [63:0] v, logic f, int nt, t_rkind rk,
                                    logic [31:0] rkey, logic [63:0] rval);
        row_t r;
        r.cap_we = cw; r.cap = c; r.kind = k; r.key = key; r.value = v; r.found = f;
        r.n_typed = nt;
        r.typed.kind = rk; r.typed.key = rkey; r.typed.value = rval; r.typed.last = 1'b1;
        rows.push_back(r);
    endfunction

    // Check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result kind %0d key %h value %h",
                       o_result_kind, o_result_key, o_result_value);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_result_kind !== e.kind) begin
                    $error("result_kind: expected %0d, actual %0d", e.kind, o_result_kind);
                    fail_count++;
                end
                if (o_result_key !== e.key) begin
                    $error("result_key: expected %h, actual %h", e.key, o_result_key);
                    fail_count++;
                end
                if (o_result_value !== e.value) begin
                    $error("result_value: expected %h, actual %h", e.value, o_result_value);
                    fail_count++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, actual %0d", e.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls in random bursts; none while quiet.
    int unsigned stall_left;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(0, 12);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT) begin
            $display("[lru_writeback_cache_top] ERROR");
            $finish;
        end
    end

    initial begin
        logic [4:0]  caps[8];
        logic [31:0] key;
        logic [63:0] val;
        int unsigned pick;
        int          did_pause;
        result_t     none;

        i_clk = 1'b0; i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = '0;
        i_valid = 1'b0; i_kind = K_GET; i_lookup_key = '0; i_write_value = '0;
        i_fill_found = 1'b0; i_stall = 1'b0;
        stall_left = 0; quiet = 1'b0; fail_count = 0; cycle_count = 0; did_pause = 0;
        none.kind = RK_READ; none.key = '0; none.value = '0; none.last = 1'b1;
        for (int i = 0; i < NWAYS; i++) begin
            way_key[i] = '0; way_value[i] = '0; way_valid[i] = 1'b0;
            way_dirty[i] = 1'b0; way_age[i] = 0;
        end
        fill_count = 0; miss_open = 1'b0; miss_key = '0; cap_reg = 5'(CAP_RESET);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows: extremes, every kind, the awkward miss/fill orderings.
        add_row(0, 0, K_GET,   32'h0, 64'h0, 0, 1, RK_FETCH, 32'h0, 64'h0);
        add_row(0, 0, K_FILL,  32'h0, 64'h0, 0, 1, RK_NOTFOUND, 32'h0, 64'h0);
        add_row(0, 0, K_FILL,  32'h0, '1, 1, 0, RK_READ, 32'h0, 64'h0);  // no miss open
        add_row(0, 0, K_FLUSH, 32'h0, 64'h0, 0, 1, RK_FLUSHDONE, 32'h0, 64'h0);
        add_row(0, 0, K_SET,   32'h0, 64'h0, 0, 1, RK_SETDONE, 32'h0, 64'h0);
        add_row(0, 0, K_SET,   '1, '1, 1, 1, RK_SETDONE, 32'h0, 64'h0);
        add_row(0, 0, K_GET,   '1, 64'h0, 0, 1, RK_READ, 32'h0, '1);
        add_row(0, 0, K_GET,   32'h5, 64'h0, 0, 1, RK_FETCH, 32'h5, 64'h0);
        add_row(0, 0, K_SET,   32'h5, 64'h5555_aaaa_0f0f_f0f0, 0, 1, RK_SETDONE, 0, 0);
        add_row(0, 0, K_FILL,  32'h0, 64'h1234, 1, -1, RK_READ, 0, 0);   // key got cached
        add_row(0, 0, K_GET,   32'h6, 64'h0, 0, 1, RK_FETCH, 32'h6, 64'h0);
        add_row(0, 0, K_GET,   32'h7, 64'h0, 0, 1, RK_FETCH, 32'h7, 64'h0); // replaces miss
        add_row(0, 0, K_FILL,  32'h0, 64'hdead_beef_0000_0001, 1, -1, RK_READ, 0, 0);
        add_row(0, 0, K_FLUSH, 32'h0, 64'h0, 0, -1, RK_READ, 0, 0);
        add_row(0, 0, K_FLUSH, 32'h0, 64'h0, 0, 1, RK_FLUSHDONE, 32'h0, 64'h0);
        add_row(1, 1, K_SET,   32'h9, 64'h99, 0, -1, RK_READ, 0, 0);     // shrink below fill
        add_row(0, 0, K_SET,   32'ha, 64'haa, 0, -1, RK_READ, 0, 0);
        add_row(0, 0, K_GET,   32'hb, 64'h0, 0, 1, RK_FETCH, 32'hb, 64'h0);
        add_row(0, 0, K_FILL,  32'h0, 64'hbb, 1, -1, RK_READ, 0, 0);
        add_row(1, 0, K_SET,   32'hc, 64'hcc, 0, -1, RK_READ, 0, 0);     // zero acts as one
        add_row(0, 0, K_SET,   32'hd, 64'hdd, 0, -1, RK_READ, 0, 0);
        add_row(1, 31, K_SET,  32'he, 64'hee, 0, -1, RK_READ, 0, 0);     // clamps to ways
        add_row(0, 0, K_FLUSH, 32'h0, 64'h0, 0, -1, RK_READ, 0, 0);

        write_cap(5'(CAP_RESET));
        foreach (rows[i]) begin
            if (rows[i].cap_we) begin
                wait_idle();
                write_cap(rows[i].cap);
            end
            send_item(rows[i].kind, rows[i].key, rows[i].value, rows[i].found,
                      rows[i].n_typed, rows[i].typed);
        end

        // Random phases, each at its own capacity; the last one runs with no idling.
        caps = '{5'd2, 5'd31, 5'd0, 5'd3, 5'd16, 5'd5, 5'd1, 5'd8};
        foreach (caps[p]) begin
            wait_idle();
            write_cap(caps[p]);
            if (p == 7) quiet = 1'b1;
            key_pool.delete();
            key_pool.push_back('0);
            key_pool.push_back('1);
            for (int i = 0; i < 18; i++) key_pool.push_back($urandom);
            for (int n = 0; n < 25; n++) begin
                if (p == 3 && n == 16) begin
                    // hold off until every outstanding result has come back
                    i_valid <= 1'b0;
                    while (pending_results.size() > 0) @(negedge i_clk);
                    did_pause++;
                end
                key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 19)] : $urandom;
                val = {$urandom, $urandom};
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    send_item(K_GET, key, val, $urandom_range(0, 1), -1, none);
                    if ($urandom_range(0, 9) < 7)
                        send_item(K_FILL, $urandom, {$urandom, $urandom},
                                  $urandom_range(0, 6) != 0, -1, none);
                end else if (pick < 75) begin
                    send_item(K_SET, key, val, $urandom_range(0, 1), -1, none);
                end else if (pick < 83) begin
                    send_item(K_FILL, key, val, $urandom_range(0, 1), -1, none);
                end else if (pick < 90) begin
                    send_item(K_FLUSH, key, val, $urandom_range(0, 1), -1, none);
                end else begin
                    send_item(t_kind'($urandom_range(0, 3)), $urandom, val,
                              $urandom_range(0, 1), -1, none);
                end
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("[lru_writeback_cache_top] OK");
        end else begin
            $display("[lru_writeback_cache_top] ERROR");
        end
        $finish;
    end

endmodule
